[src/nmsv_pkg.sv]
// Shared types and constants for the NAND micro-sequencer.
// No dependencies; used by nmsv_exec, nmsv_outq and the top level.
package nmsv_pkg;

  // Input request types
  localparam logic [1:0] REQ_START = 2'd0;
  localparam logic [1:0] REQ_INSTR = 2'd1;
  localparam logic [1:0] REQ_RDATA = 2'd2;

  // Opcodes
  localparam logic [7:0] OP_TERM    = 8'h00;
  localparam logic [7:0] OP_NWR_IMM = 8'h01;
  localparam logic [7:0] OP_NWR_REG = 8'h02;
  localparam logic [7:0] OP_MRD     = 8'h03;
  localparam logic [7:0] OP_NRD_MSK = 8'h04;
  localparam logic [7:0] OP_LDI     = 8'h05;
  localparam logic [7:0] OP_MOV     = 8'h06;
  localparam logic [7:0] OP_WAIT    = 8'h07;
  localparam logic [7:0] OP_AND     = 8'h0a;
  localparam logic [7:0] OP_OR      = 8'h0b;
  localparam logic [7:0] OP_ADD     = 8'h0c;
  localparam logic [7:0] OP_SUB     = 8'h0d;
  localparam logic [7:0] OP_JNZ     = 8'h0e;
  localparam logic [7:0] OP_MWR     = 8'h11;
  localparam logic [7:0] OP_SHL     = 8'h13;
  localparam logic [7:0] OP_SHR     = 8'h14;
  localparam logic [7:0] OP_JZ      = 8'h17;
  localparam logic [7:0] OP_NRD_REG = 8'h18;
  localparam logic [7:0] OP_NWR_IND = 8'h19;

  // Memory-space address bit flipped on reads, cleared on writes
  localparam logic [31:0] MEM_FLIP = 32'h8000_0000;
  localparam logic [31:0] PC_STEP  = 32'd8;

  // Result queue depth: one waiting entry plus room for a two-result item
  localparam int unsigned OQ_DEPTH = 3;

  typedef enum logic [2:0] {
    KIND_FETCH  = 3'd0,
    KIND_NWRITE = 3'd1,
    KIND_NREAD  = 3'd2,
    KIND_MREAD  = 3'd3,
    KIND_MWRITE = 3'd4,
    KIND_DONE   = 3'd5,
    KIND_BADOP  = 3'd6,
    KIND_UNEXP  = 3'd7
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] addr;
    logic [31:0] data;
    logic        last;
  } res_t;

endpackage

[src/nmsv_ram.sv]
// Generic RAM: one write port, two registered read ports.
// No dependencies.
module nmsv_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

[src/nmsv_exec.sv]
// Execute stage: decode, operand select, ALU and sequencer state.
// Depends on nmsv_pkg; register file data comes from an nmsv_ram instance.
module nmsv_exec #(
  parameter int unsigned NUM_REGS = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        fire_i,
  input  logic [1:0]                  req_i,
  input  logic [31:0]                 start_addr_i,
  input  logic [63:0]                 instr_i,
  input  logic [31:0]                 rdata_i,
  input  logic [31:0]                 ram_a_i,
  input  logic [31:0]                 ram_b_i,
  output logic                        wr_en_o,
  output logic [$clog2(NUM_REGS)-1:0] wr_addr_o,
  output logic [31:0]                 wr_data_o,
  output nmsv_pkg::res_t              res0_o,
  output nmsv_pkg::res_t              res1_o,
  output logic                        two_o
);

  localparam int unsigned RegAw = $clog2(NUM_REGS);

  // Sequencer state
  logic [31:0]       pc_q, pc_d;
  logic [31:0]       pstart_q, pstart_d;
  logic              run_q, run_d;
  logic              wait_q, wait_d;
  logic [RegAw-1:0]  pdest_q, pdest_d;
  logic [31:0]       pmask_q, pmask_d;
  logic [NUM_REGS-1:0] rvld_q;
  logic              clr_all;
  logic              we_raw;

  // Write-back bypass for the RAM's read-before-write
  logic              fwd_vld_q;
  logic [RegAw-1:0]  fwd_addr_q;
  logic [31:0]       fwd_data_q;

  // Decode
  logic [31:0]      imm, srcf, rd, rs, nxt, jmp;
  logic [7:0]       op;
  logic [RegAw-1:0] d, s;
  logic [31:0]      alu_a, alu_b, alu_y;

  assign imm  = instr_i[63:32];
  assign op   = instr_i[31:24];
  assign d    = instr_i[16 +: RegAw];
  assign s    = instr_i[0 +: RegAw];
  assign srcf = {16'h0000, instr_i[15:0]};
  assign nxt  = pc_q + nmsv_pkg::PC_STEP;
  assign jmp  = pstart_q + imm;

  // Operand select: bypass, then RAM data if the entry was written since start
  assign rd = (fwd_vld_q && fwd_addr_q == d) ? fwd_data_q : (rvld_q[d] ? ram_a_i : '0);
  assign rs = (fwd_vld_q && fwd_addr_q == s) ? fwd_data_q : (rvld_q[s] ? ram_b_i : '0);

  // ALU: register-register form when imm is zero
  assign alu_a = (imm == '0) ? rd : rs;
  assign alu_b = (imm == '0) ? rs : imm;

  always_comb begin
    case (op)
      nmsv_pkg::OP_AND: alu_y = alu_a & alu_b;
      nmsv_pkg::OP_OR:  alu_y = alu_a | alu_b;
      nmsv_pkg::OP_ADD: alu_y = alu_a + alu_b;
      nmsv_pkg::OP_SUB: alu_y = alu_a - alu_b;
      nmsv_pkg::OP_SHL: alu_y = (|alu_b[31:5]) ? '0 : (alu_a << alu_b[4:0]);
      default:          alu_y = (|alu_b[31:5]) ? '0 : (alu_a >> alu_b[4:0]);
    endcase
  end

  // Next state and results
  always_comb begin
    pc_d      = pc_q;
    pstart_d  = pstart_q;
    run_d     = run_q;
    wait_d    = wait_q;
    pdest_d   = pdest_q;
    pmask_d   = pmask_q;
    clr_all   = 1'b0;
    we_raw    = 1'b0;
    wr_addr_o = d;
    wr_data_o = alu_y;
    two_o     = 1'b0;
    res0_o.kind = nmsv_pkg::KIND_UNEXP;
    res0_o.addr = pc_q;
    res0_o.data = '0;
    res0_o.last = 1'b1;
    res1_o.kind = nmsv_pkg::KIND_FETCH;
    res1_o.addr = nxt;
    res1_o.data = '0;
    res1_o.last = 1'b1;

    if (req_i == nmsv_pkg::REQ_START) begin
      clr_all     = 1'b1;
      pstart_d    = start_addr_i;
      pc_d        = start_addr_i;
      run_d       = 1'b1;
      wait_d      = 1'b0;
      pdest_d     = '0;
      pmask_d     = '0;
      res0_o.kind = nmsv_pkg::KIND_FETCH;
      res0_o.addr = start_addr_i;
    end else if (req_i == nmsv_pkg::REQ_RDATA && wait_q) begin
      we_raw      = 1'b1;
      wr_addr_o   = pdest_q;
      wr_data_o   = rdata_i & pmask_q;
      wait_d      = 1'b0;
      res0_o.kind = nmsv_pkg::KIND_FETCH;
    end else if (req_i == nmsv_pkg::REQ_INSTR && run_q && !wait_q) begin
      pc_d        = nxt;
      res0_o.kind = nmsv_pkg::KIND_FETCH;
      res0_o.addr = nxt;
      case (op)
        nmsv_pkg::OP_TERM: begin
          run_d       = 1'b0;
          pc_d        = pc_q;
          res0_o.kind = nmsv_pkg::KIND_DONE;
          res0_o.addr = pc_q;
        end
        nmsv_pkg::OP_NWR_IMM, nmsv_pkg::OP_NWR_REG: begin
          two_o       = 1'b1;
          res0_o.kind = nmsv_pkg::KIND_NWRITE;
          res0_o.addr = srcf;
          res0_o.data = (op == nmsv_pkg::OP_NWR_IMM) ? imm : rd;
          res0_o.last = 1'b0;
        end
        nmsv_pkg::OP_NWR_IND: begin
          two_o       = 1'b1;
          res0_o.kind = nmsv_pkg::KIND_NWRITE;
          res0_o.addr = rs;
          res0_o.data = rd;
          res0_o.last = 1'b0;
        end
        nmsv_pkg::OP_MWR: begin
          two_o       = 1'b1;
          res0_o.kind = nmsv_pkg::KIND_MWRITE;
          res0_o.addr = rs & ~nmsv_pkg::MEM_FLIP;
          res0_o.data = rd;
          res0_o.last = 1'b0;
        end
        nmsv_pkg::OP_MRD: begin
          wait_d      = 1'b1;
          pdest_d     = d;
          pmask_d     = '1;
          res0_o.kind = nmsv_pkg::KIND_MREAD;
          res0_o.addr = rs ^ nmsv_pkg::MEM_FLIP;
        end
        nmsv_pkg::OP_NRD_MSK: begin
          wait_d      = 1'b1;
          pdest_d     = d;
          pmask_d     = imm;
          res0_o.kind = nmsv_pkg::KIND_NREAD;
          res0_o.addr = srcf;
        end
        nmsv_pkg::OP_NRD_REG: begin
          wait_d      = 1'b1;
          pdest_d     = d;
          pmask_d     = '1;
          res0_o.kind = nmsv_pkg::KIND_NREAD;
          res0_o.addr = rs;
        end
        nmsv_pkg::OP_LDI: begin
          we_raw    = 1'b1;
          wr_data_o = imm;
        end
        nmsv_pkg::OP_MOV: begin
          we_raw    = 1'b1;
          wr_data_o = rs;
        end
        nmsv_pkg::OP_WAIT: begin
        end
        nmsv_pkg::OP_AND, nmsv_pkg::OP_OR, nmsv_pkg::OP_ADD,
        nmsv_pkg::OP_SUB, nmsv_pkg::OP_SHL, nmsv_pkg::OP_SHR: begin
          we_raw = 1'b1;
        end
        nmsv_pkg::OP_JNZ: begin
          if (rd != '0) begin
            pc_d        = jmp;
            res0_o.addr = jmp;
          end
        end
        nmsv_pkg::OP_JZ: begin
          if (rd == '0) begin
            pc_d        = jmp;
            res0_o.addr = jmp;
          end
        end
        default: begin
          run_d       = 1'b0;
          pc_d        = pc_q;
          res0_o.kind = nmsv_pkg::KIND_BADOP;
          res0_o.addr = pc_q;
        end
      endcase
    end
  end

  assign wr_en_o = fire_i && we_raw;

  // State registers update only when an item executes; fwd_vld_q updates every cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q      <= '0;
      pstart_q  <= '0;
      run_q     <= 1'b0;
      wait_q    <= 1'b0;
      pdest_q   <= '0;
      pmask_q   <= '0;
      rvld_q    <= '0;
      fwd_vld_q <= 1'b0;
    end else begin
      fwd_vld_q <= wr_en_o;
      if (fire_i) begin
        pc_q     <= pc_d;
        pstart_q <= pstart_d;
        run_q    <= run_d;
        wait_q   <= wait_d;
        pdest_q  <= pdest_d;
        pmask_q  <= pmask_d;
        if (clr_all) begin
          rvld_q <= '0;
        end else if (we_raw) begin
          rvld_q[wr_addr_o] <= 1'b1;
        end
      end
    end
  end

  // Bypass payload
  always_ff @(posedge clk_i) begin
    if (wr_en_o) begin
      fwd_addr_q <= wr_addr_o;
      fwd_data_q <= wr_data_o;
    end
  end

endmodule

[src/nmsv_outq.sv]
// Result queue: takes one or two results per item, gives one per cycle when ready.
// Depends on nmsv_pkg.
module nmsv_outq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  logic           two_i,
  input  nmsv_pkg::res_t res0_i,
  input  nmsv_pkg::res_t res1_i,
  output logic           room_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output nmsv_pkg::res_t head_o
);

  localparam int unsigned CntW = $clog2(nmsv_pkg::OQ_DEPTH + 1);

  nmsv_pkg::res_t ent_q [nmsv_pkg::OQ_DEPTH];
  nmsv_pkg::res_t ent_d [nmsv_pkg::OQ_DEPTH];
  logic [CntW-1:0] cnt_q, cnt_d, base;
  logic            pop;

  assign out_valid_o = (cnt_q != '0);
  assign head_o      = ent_q[0];
  assign pop         = out_valid_o && out_ready_i;
  assign base        = cnt_q - CntW'(pop);
  // Room for a two-result item after this cycle's pop
  assign room_o      = (base <= CntW'(nmsv_pkg::OQ_DEPTH - 2));
  assign cnt_d       = base + CntW'(push_i) + CntW'(push_i && two_i);

  // Shift out the head, then append behind the survivors
  always_comb begin
    for (int i = 0; i < nmsv_pkg::OQ_DEPTH; i++) begin
      if (pop && i < nmsv_pkg::OQ_DEPTH - 1) begin
        ent_d[i] = ent_q[i + 1];
      end else begin
        ent_d[i] = ent_q[i];
      end
      if (push_i && CntW'(i) == base) begin
        ent_d[i] = res0_i;
      end
      if (push_i && two_i && CntW'(i) == base + CntW'(1)) begin
        ent_d[i] = res1_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < nmsv_pkg::OQ_DEPTH; i++) begin
      ent_q[i] <= ent_d[i];
    end
  end

endmodule

[src/nand_microsequencer_vm.sv]
// Top level of the NAND controller micro-sequencer.
// Depends on nmsv_pkg, nmsv_ram, nmsv_exec and nmsv_outq.
//
//   channel | direction | handshake                | payload
//   --------+-----------+--------------------------+-------------------------------------
//   in      | to block  | in_valid_i / in_ready_o   | req_type, start_address, instruction,
//           |           |                          | read_data
//   out     | from block| out_valid_o / out_ready_i | request_kind, bus_address,
//           |           |                          | write_data, last
//
// An accepted request waits in the input register while the register file RAM
// is read, executes once the result queue has room, and lands in a three-entry
// result queue, whose head is presented on the output port.
// Throughput is one request per cycle while the result queue has room; a request
// with two results (a write followed by a fetch) delivers them one after the other.
// The block stalls input only when the result queue cannot take two more results.
// Reset clears the sequencer state; register file entries read as zero until written.
module nand_microsequencer_vm #(
  parameter int unsigned NUM_REGS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  req_type_i,
  input  logic [31:0] start_address_i,
  input  logic [63:0] instruction_i,
  input  logic [31:0] read_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  request_kind_o,
  output logic [31:0] bus_address_o,
  output logic [31:0] write_data_o,
  output logic        last_o
);

  localparam int unsigned RegAw = $clog2(NUM_REGS);

  // Input register
  logic        ivld_q;
  logic [1:0]  req_q;
  logic [31:0] start_q;
  logic [63:0] instr_q;
  logic [31:0] rdata_q;
  logic        fire, room, accept;

  logic             wr_en;
  logic [RegAw-1:0] wr_addr;
  logic [31:0]      wr_data;
  logic [RegAw-1:0] raddr_a, raddr_b;
  logic [31:0]      ram_a, ram_b;
  nmsv_pkg::res_t   res0, res1, head;
  logic             two;

  assign fire       = ivld_q && room;
  assign in_ready_o = !ivld_q || fire;
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ivld_q <= 1'b0;
    end else if (in_ready_o) begin
      ivld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q   <= req_type_i;
      start_q <= start_address_i;
      instr_q <= instruction_i;
      rdata_q <= read_data_i;
    end
  end

  // Register file read follows the request that will sit in the input register
  assign raddr_a = in_ready_o ? instruction_i[16 +: RegAw] : instr_q[16 +: RegAw];
  assign raddr_b = in_ready_o ? instruction_i[0 +: RegAw]  : instr_q[0 +: RegAw];

  nmsv_ram #(
    .WIDTH (32),
    .DEPTH (NUM_REGS)
  ) u_regs (
    .clk_i     (clk_i),
    .we_i      (wr_en),
    .waddr_i   (wr_addr),
    .wdata_i   (wr_data),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .rdata_a_o (ram_a),
    .rdata_b_o (ram_b)
  );

  nmsv_exec #(
    .NUM_REGS (NUM_REGS)
  ) u_exec (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (fire),
    .req_i        (req_q),
    .start_addr_i (start_q),
    .instr_i      (instr_q),
    .rdata_i      (rdata_q),
    .ram_a_i      (ram_a),
    .ram_b_i      (ram_b),
    .wr_en_o      (wr_en),
    .wr_addr_o    (wr_addr),
    .wr_data_o    (wr_data),
    .res0_o       (res0),
    .res1_o       (res1),
    .two_o        (two)
  );

  nmsv_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (fire),
    .two_i       (two),
    .res0_i      (res0),
    .res1_i      (res1),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .head_o      (head)
  );

  assign request_kind_o = head.kind;
  assign bus_address_o  = head.addr;
  assign write_data_o   = head.data;
  assign last_o         = head.last;

  // Checks
  a_push_visible: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_valid_o)
    else $error("executed request left no result in the queue");

  a_two_only_instr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && two |-> req_q == nmsv_pkg::REQ_INSTR)
    else $error("two results from a non-instruction request");

  a_start_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && req_q == nmsv_pkg::REQ_START |-> !wr_en)
    else $error("register write on a start request");

endmodule

[verif/testbench.sv]
// Self-checking testbench for the NAND micro-sequencer: directed and random requests,
// with results checked against a behavioral predictor kept inside this file.
// Depends on nmsv_pkg and nand_microsequencer_vm.
module testbench;

  // Request type with no meaning; the block must flag it as unexpected
  localparam logic [1:0] REQ_BAD  = 2'd3;
  // Opcode outside the instruction set
  localparam logic [7:0] OP_UNDEF = 8'hff;
  localparam int CYCLE_LIMIT      = 200000;
  localparam int DRAIN_CYCLES     = 8;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [1:0]  req_type_i;
  logic [31:0] start_address_i;
  logic [63:0] instruction_i;
  logic [31:0] read_data_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [2:0]  request_kind_o;
  logic [31:0] bus_address_o;
  logic [31:0] write_data_o;
  logic        last_o;

  nand_microsequencer_vm DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .req_type_i     (req_type_i),
    .start_address_i(start_address_i),
    .instruction_i  (instruction_i),
    .read_data_i    (read_data_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .request_kind_o (request_kind_o),
    .bus_address_o  (bus_address_o),
    .write_data_o   (write_data_o),
    .last_o         (last_o)
  );

  // Predictor state: register file, pc, program base and read bookkeeping
  logic [31:0] gpr [8];
  logic [31:0] pc;
  logic [31:0] prog_base;
  logic        is_running;
  logic        read_pending;
  logic [2:0]  rd_dest;
  logic [31:0] rd_mask;

  nmsv_pkg::res_t expected_q[$];
  nmsv_pkg::res_t head_res;
  int   err_count;
  int   cycle_count;
  int   in_idle_pct;
  int   out_stall_pct;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic logic [31:0] alu_result(input logic [7:0] op, input logic [31:0] a,
                                             input logic [31:0] b);
    case (op)
      nmsv_pkg::OP_AND: return a & b;
      nmsv_pkg::OP_OR:  return a | b;
      nmsv_pkg::OP_ADD: return a + b;
      nmsv_pkg::OP_SUB: return a - b;
      nmsv_pkg::OP_SHL: return (b >= 32) ? 32'd0 : (a << b[4:0]);
      default:          return (b >= 32) ? 32'd0 : (a >> b[4:0]);
    endcase
  endfunction

  function void push_result(input nmsv_pkg::kind_e kind, input logic [31:0] addr,
                            input logic [31:0] data, input logic last);
    nmsv_pkg::res_t r;
    r.kind = kind;
    r.addr = addr;
    r.data = data;
    r.last = last;
    expected_q.push_back(r);
  endfunction

  // Update the predictor with one accepted request and queue the bus requests it causes
  function void exec_request(input logic [1:0] req, input logic [31:0] start,
                             input logic [63:0] ins, input logic [31:0] rdata);
    logic [31:0] imm;
    logic [7:0]  op;
    logic [2:0]  d;
    logic [2:0]  s;
    logic [15:0] srcf;
    logic [31:0] rd;
    logic [31:0] rs;
    logic [31:0] next_pc;
    logic        fetch_next;
    int          i;
    imm     = ins[63:32];
    op      = ins[31:24];
    d       = ins[18:16];
    srcf    = ins[15:0];
    s       = ins[2:0];
    rd      = gpr[d];
    rs      = gpr[s];
    next_pc = pc + nmsv_pkg::PC_STEP;
    fetch_next = 1'b0;
    if (req == nmsv_pkg::REQ_START) begin
      for (i = 0; i < 8; i++) gpr[i] = '0;
      prog_base    = start;
      pc           = start;
      is_running   = 1'b1;
      read_pending = 1'b0;
      rd_dest      = '0;
      rd_mask      = '0;
      push_result(nmsv_pkg::KIND_FETCH, pc, '0, 1'b1);
    end else if (req == nmsv_pkg::REQ_RDATA && read_pending) begin
      gpr[rd_dest] = rdata & rd_mask;
      read_pending = 1'b0;
      push_result(nmsv_pkg::KIND_FETCH, pc, '0, 1'b1);
    end else if (req != nmsv_pkg::REQ_INSTR || !is_running || read_pending) begin
      push_result(nmsv_pkg::KIND_UNEXP, pc, '0, 1'b1);
    end else begin
      case (op)
        nmsv_pkg::OP_TERM: begin
          is_running = 1'b0;
          push_result(nmsv_pkg::KIND_DONE, pc, '0, 1'b1);
        end
        nmsv_pkg::OP_NWR_IMM: begin
          push_result(nmsv_pkg::KIND_NWRITE, {16'h0, srcf}, imm, 1'b0);
          fetch_next = 1'b1;
        end
        nmsv_pkg::OP_NWR_REG: begin
          push_result(nmsv_pkg::KIND_NWRITE, {16'h0, srcf}, rd, 1'b0);
          fetch_next = 1'b1;
        end
        nmsv_pkg::OP_MRD, nmsv_pkg::OP_NRD_MSK, nmsv_pkg::OP_NRD_REG: begin
          read_pending = 1'b1;
          rd_dest      = d;
          rd_mask      = (op == nmsv_pkg::OP_NRD_MSK) ? imm : 32'hffff_ffff;
          pc           = next_pc;
          if (op == nmsv_pkg::OP_MRD) begin
            push_result(nmsv_pkg::KIND_MREAD, rs ^ nmsv_pkg::MEM_FLIP, '0, 1'b1);
          end else if (op == nmsv_pkg::OP_NRD_MSK) begin
            push_result(nmsv_pkg::KIND_NREAD, {16'h0, srcf}, '0, 1'b1);
          end else begin
            push_result(nmsv_pkg::KIND_NREAD, rs, '0, 1'b1);
          end
        end
        nmsv_pkg::OP_LDI: begin
          gpr[d] = imm;
          fetch_next = 1'b1;
        end
        nmsv_pkg::OP_MOV: begin
          gpr[d] = rs;
          fetch_next = 1'b1;
        end
        nmsv_pkg::OP_WAIT: fetch_next = 1'b1;
        nmsv_pkg::OP_AND, nmsv_pkg::OP_OR, nmsv_pkg::OP_ADD,
        nmsv_pkg::OP_SUB, nmsv_pkg::OP_SHL, nmsv_pkg::OP_SHR: begin
          // zero immediate selects the register-register form
          gpr[d] = (imm == 0) ? alu_result(op, rd, rs) : alu_result(op, rs, imm);
          fetch_next = 1'b1;
        end
        nmsv_pkg::OP_JNZ: begin
          if (rd != 0) next_pc = prog_base + imm;
          fetch_next = 1'b1;
        end
        nmsv_pkg::OP_JZ: begin
          if (rd == 0) next_pc = prog_base + imm;
          fetch_next = 1'b1;
        end
        nmsv_pkg::OP_MWR: begin
          push_result(nmsv_pkg::KIND_MWRITE, rs & ~nmsv_pkg::MEM_FLIP, rd, 1'b0);
          fetch_next = 1'b1;
        end
        nmsv_pkg::OP_NWR_IND: begin
          push_result(nmsv_pkg::KIND_NWRITE, rs, rd, 1'b0);
          fetch_next = 1'b1;
        end
        default: begin
          is_running = 1'b0;
          push_result(nmsv_pkg::KIND_BADOP, pc, '0, 1'b1);
        end
      endcase
      if (fetch_next) begin
        pc = next_pc;
        push_result(nmsv_pkg::KIND_FETCH, pc, '0, 1'b1);
      end
    end
  endfunction

  function void check_field(input string name, input logic [31:0] want,
                            input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      err_count++;
    end
  endfunction

  // Predict on every accepted request, then check every accepted result
  always @(posedge clk_i) begin
    cycle_count++;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o)
        exec_request(req_type_i, start_address_i, instruction_i, read_data_i);
      if (out_valid_o && out_ready_i) begin
        if (expected_q.size() == 0) begin
          $display("%0t: result with none expected, expected none, actual kind %0d addr %h",
                   $time, request_kind_o, bus_address_o);
          err_count++;
        end else begin
          head_res = expected_q.pop_front();
          check_field("request_kind", {29'h0, head_res.kind}, {29'h0, request_kind_o});
          check_field("bus_address", head_res.addr, bus_address_o);
          check_field("write_data", head_res.data, write_data_o);
          check_field("last", {31'h0, head_res.last}, {31'h0, last_o});
        end
      end
    end
  end

  // Receiver: stall at random at the current rate
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      out_ready_i = ($urandom_range(99) >= out_stall_pct);
    end
  end

  // Watchdog
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("status: fail");
    $finish;
  end

  // Send one request; called and returning at a falling edge
  task automatic send_req(input logic [1:0] req, input logic [31:0] start,
                          input logic [63:0] ins, input logic [31:0] rdata);
    int gap;
    gap = 0;
    while ($urandom_range(99) < in_idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_type_i      = req;
    start_address_i = start;
    instruction_i   = ins;
    read_data_i     = rdata;
    in_valid_i      = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  task automatic send_start(input logic [31:0] addr);
    send_req(nmsv_pkg::REQ_START, addr, {$urandom, $urandom}, $urandom);
  endtask

  task automatic send_ins(input logic [7:0] op, input logic [7:0] dest,
                          input logic [15:0] src, input logic [31:0] imm);
    send_req(nmsv_pkg::REQ_INSTR, $urandom, {imm, op, dest, src}, $urandom);
  endtask

  task automatic send_rdata(input logic [31:0] data);
    send_req(nmsv_pkg::REQ_RDATA, $urandom, {$urandom, $urandom}, data);
  endtask

  // Hold off the sender until every expected result has come back
  task automatic wait_drained();
    in_valid_i = 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Each opcode but OP_TERM, field extremes, shifts past 31, jumps with wrap
  task automatic test_opcodes();
    in_idle_pct   = 0;
    out_stall_pct = 0;
    send_start(32'hffff_fff8);
    send_ins(nmsv_pkg::OP_LDI, 8'hf9, 16'hfff0, 32'hffff_ffff);   // pc wraps to zero
    send_ins(nmsv_pkg::OP_LDI, 8'h02, 16'h0000, 32'd36);
    send_ins(nmsv_pkg::OP_SHL, 8'h01, 16'h0002, 32'd0);           // shift by register, 36
    send_ins(nmsv_pkg::OP_LDI, 8'h03, 16'h0000, 32'h8000_0001);
    send_ins(nmsv_pkg::OP_SHR, 8'h04, 16'h0003, 32'd31);
    send_ins(nmsv_pkg::OP_SHL, 8'h07, 16'h0003, 32'd32);          // shift by immediate, 32
    send_ins(nmsv_pkg::OP_ADD, 8'h03, 16'h0003, 32'd0);
    send_ins(nmsv_pkg::OP_SUB, 8'h05, 16'h0004, 32'd2);
    send_ins(nmsv_pkg::OP_AND, 8'h06, 16'h0005, 32'h0f0f_0f0f);
    send_ins(nmsv_pkg::OP_OR, 8'h06, 16'h0003, 32'd0);
    send_ins(nmsv_pkg::OP_MOV, 8'h00, 16'hfff5, 32'd0);
    send_ins(nmsv_pkg::OP_WAIT, 8'hff, 16'hffff, 32'hffff_ffff);
    send_ins(nmsv_pkg::OP_NWR_IMM, 8'h00, 16'hffff, 32'hffff_ffff);
    send_ins(nmsv_pkg::OP_NWR_REG, 8'h05, 16'h1234, 32'd0);
    send_ins(nmsv_pkg::OP_MRD, 8'h07, 16'h0005, 32'd0);
    send_rdata(32'hffff_ffff);
    send_ins(nmsv_pkg::OP_NRD_MSK, 8'h02, 16'habcd, 32'h00ff_f00f);
    send_rdata($urandom);
    send_ins(nmsv_pkg::OP_NRD_REG, 8'h01, 16'h0006, 32'd0);
    send_rdata(32'd0);
    send_ins(nmsv_pkg::OP_MWR, 8'h06, 16'h0005, 32'd0);
    send_ins(nmsv_pkg::OP_NWR_IND, 8'h05, 16'h0003, 32'd0);
    send_ins(nmsv_pkg::OP_JNZ, 8'h05, 16'h0000, 32'h0000_0100);   // taken
    send_ins(nmsv_pkg::OP_JNZ, 8'h01, 16'h0000, 32'h0000_0040);   // not taken
    send_ins(nmsv_pkg::OP_JZ, 8'h01, 16'h0000, 32'hffff_fff0);    // taken, wraps
    send_ins(nmsv_pkg::OP_JZ, 8'h05, 16'h0000, 32'h0000_0010);    // not taken
    send_ins(OP_UNDEF, 8'h00, 16'h0000, 32'd0);
    wait_drained();
  endtask

  // Requests out of place, restart during a read, terminate
  task automatic test_unexpected();
    send_ins(nmsv_pkg::OP_LDI, 8'h01, 16'h0000, 32'd5);
    send_rdata($urandom);
    send_req(REQ_BAD, $urandom, {$urandom, $urandom}, $urandom);
    send_start($urandom);
    send_ins(nmsv_pkg::OP_MRD, 8'h03, 16'h0001, 32'd0);
    send_ins(nmsv_pkg::OP_LDI, 8'h01, 16'h0000, 32'd5);
    send_req(REQ_BAD, $urandom, {$urandom, $urandom}, $urandom);
    send_start($urandom);                               // cancels the pending read
    send_rdata($urandom);
    send_ins(nmsv_pkg::OP_TERM, 8'h00, 16'h0000, 32'd0);
    send_ins(nmsv_pkg::OP_WAIT, 8'h00, 16'h0000, 32'd0);
    wait_drained();
  endtask

  task automatic send_random_ins();
    logic [7:0]  op;
    logic [31:0] imm;
    int          pick;
    pick = $urandom_range(99);
    if (pick < 2) op = nmsv_pkg::OP_TERM;
    else if (pick < 4) op = 8'($urandom_range(255));
    else begin
      case ($urandom_range(17))
        0:       op = nmsv_pkg::OP_NWR_IMM;
        1:       op = nmsv_pkg::OP_NWR_REG;
        2:       op = nmsv_pkg::OP_MRD;
        3:       op = nmsv_pkg::OP_NRD_MSK;
        4:       op = nmsv_pkg::OP_LDI;
        5:       op = nmsv_pkg::OP_MOV;
        6:       op = nmsv_pkg::OP_WAIT;
        7:       op = nmsv_pkg::OP_AND;
        8:       op = nmsv_pkg::OP_OR;
        9:       op = nmsv_pkg::OP_ADD;
        10:      op = nmsv_pkg::OP_SUB;
        11:      op = nmsv_pkg::OP_JNZ;
        12:      op = nmsv_pkg::OP_MWR;
        13:      op = nmsv_pkg::OP_SHL;
        14:      op = nmsv_pkg::OP_SHR;
        15:      op = nmsv_pkg::OP_JZ;
        16:      op = nmsv_pkg::OP_NRD_REG;
        default: op = nmsv_pkg::OP_NWR_IND;
      endcase
    end
    case ($urandom_range(3))
      0:       imm = 32'd0;
      1:       imm = $urandom_range(40);
      default: imm = $urandom;
    endcase
    if ((op == nmsv_pkg::OP_JNZ || op == nmsv_pkg::OP_JZ) && $urandom_range(1) == 1)
      imm = $urandom_range(63) * 8;
    send_ins(op, 8'($urandom_range(255)), 16'($urandom_range(65535)), imm);
  endtask

  // Random programs steered by the predictor state, with some noise mixed in
  task automatic test_random(input int idle_pct, input int stall_pct, input int count);
    int r;
    int n;
    in_idle_pct   = idle_pct;
    out_stall_pct = stall_pct;
    for (n = 0; n < count; n++) begin
      r = $urandom_range(99);
      if (!is_running) begin
        if (r < 85) send_start($urandom);
        else if (r < 92) send_random_ins();
        else if (r < 96) send_rdata($urandom);
        else send_req(REQ_BAD, $urandom, {$urandom, $urandom}, $urandom);
      end else if (read_pending) begin
        if (r < 85) send_rdata($urandom);
        else if (r < 90) send_start($urandom);
        else if (r < 95) send_random_ins();
        else send_req(REQ_BAD, $urandom, {$urandom, $urandom}, $urandom);
      end else begin
        if (r < 92) send_random_ins();
        else if (r < 95) send_rdata($urandom);
        else if (r < 97) send_start($urandom);
        else send_req(REQ_BAD, $urandom, {$urandom, $urandom}, $urandom);
      end
    end
    wait_drained();
  endtask

  // Reset, tests in turn, final verdict
  initial begin
    err_count       = 0;
    cycle_count     = 0;
    in_idle_pct     = 0;
    out_stall_pct   = 0;
    in_valid_i      = 1'b0;
    req_type_i      = '0;
    start_address_i = '0;
    instruction_i   = '0;
    read_data_i     = '0;
    for (int i = 0; i < 8; i++) gpr[i] = '0;
    pc           = '0;
    prog_base    = '0;
    is_running   = 1'b0;
    read_pending = 1'b0;
    rd_dest      = '0;
    rd_mask      = '0;
    rst_ni       = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_opcodes();
    test_unexpected();
    test_random(0, 0, 275);
    test_random(48, 0, 275);
    test_random(0, 48, 275);
    test_random(23, 23, 275);

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_count == 0 && expected_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
